### hdl/gcm_pkg.sv
package gcm_pkg;

    localparam int unsigned FIELD_POLY_DEFAULT = 361;
    localparam int unsigned ROUNDS = 8;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_AAD   = 2'd1,
        OP_TEXT  = 2'd2,
        OP_FIN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CIPHER = 2'd0,
        KIND_TAG    = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_AAD,
        CMD_TEXT,
        CMD_FIN
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        err;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [4:0]  n;
    } job_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y,
                                          input logic [7:0] red);
        logic [7:0] acc;
        logic [7:0] v;
        acc = 8'd0;
        v = x;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) acc = acc ^ v;
            v = {v[6:0], 1'b0} ^ (v[7] ? red : 8'd0);
        end
        return acc;
    endfunction

    function automatic logic [7:0] sbox_entry(input logic [7:0] x, input logic [7:0] red);
        logic [7:0] p;
        logic [7:0] r;
        logic [7:0] sq;
        p = 8'd1;
        sq = x;
        for (int k = 0; k < 8; k++) begin
            if (k != 0) p = gf_mul(p, sq, red);
            sq = gf_mul(sq, sq, red);
        end
        for (int b = 0; b < 8; b++) begin
            r[b] = p[b] ^ p[(b + 4) % 8] ^ p[(b + 5) % 8] ^ p[(b + 6) % 8]
                 ^ p[(b + 7) % 8] ^ ((8'h63 >> b) & 8'd1) != 8'd0;
        end
        return r;
    endfunction

    function automatic logic [127:0] keep_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++) begin
            m[127 - 8 * i -: 8] = (5'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

### hdl/gcm_front.sv
module gcm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          op,
    input  logic [63:0]         bh,
    input  logic [63:0]         bl,
    input  logic [4:0]          n,
    output logic                job_valid,
    input  logic                job_ready,
    output gcm_pkg::job_t       job
);

    localparam int DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_AAD,
        PH_TEXT
    } phase_t;

    phase_t          phase_reg;
    phase_t          phase_next;
    gcm_pkg::job_t   q_reg [DEPTH];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      cnt_reg;
    gcm_pkg::job_t   cls;
    logic            push;
    logic            pop;
    logic            n_ok;

    assign in_ready = (cnt_reg != 2'(DEPTH));
    assign push = in_valid && in_ready;
    assign pop = job_valid && job_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign job = q_reg[rptr_reg];
    assign n_ok = (n >= 5'd1) && (n <= 5'd16);

    always_comb
    begin
        cls.bh = bh;
        cls.bl = bl;
        cls.n = n;
        cls.err = 1'b1;
        cls.cmd = gcm_pkg::CMD_START;
        phase_next = phase_reg;
        unique case (gcm_pkg::op_t'(op))
            gcm_pkg::OP_START:
            begin
                cls.err = 1'b0;
                phase_next = PH_AAD;
            end
            gcm_pkg::OP_AAD:
            begin
                cls.cmd = gcm_pkg::CMD_AAD;
                cls.err = !(phase_reg == PH_AAD && n_ok);
            end
            gcm_pkg::OP_TEXT:
            begin
                cls.cmd = gcm_pkg::CMD_TEXT;
                cls.err = !(phase_reg != PH_IDLE && n_ok);
                if (!cls.err) phase_next = PH_TEXT;
            end
            gcm_pkg::OP_FIN:
            begin
                cls.cmd = gcm_pkg::CMD_FIN;
                cls.err = (phase_reg == PH_IDLE);
                if (!cls.err) phase_next = PH_IDLE;
            end
            default:
            begin
                cls.err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                phase_reg <= phase_next;
                wptr_reg <= !wptr_reg;
            end
            if (pop) rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wptr_reg] <= cls;
    end

endmodule

### hdl/gcm_cipher.sv
module gcm_cipher #(
    parameter int unsigned FIELD_POLY = gcm_pkg::FIELD_POLY_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [127:0]  din,
    input  logic [255:0]  key,
    output logic          done,
    output logic [127:0]  dout
);

    localparam logic [7:0] RED = FIELD_POLY[7:0];

    logic [7:0]   sbox [256];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg;
    logic [3:0]   rnd_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  rk, s_in, t, b_n, c_n, d_n;

    always_comb
    begin
        for (int v = 0; v < 256; v++) sbox[v] = gcm_pkg::sbox_entry(8'(v), RED);
    end

    assign rk = key[255 - 32 * rnd_reg[2:0] -: 32];
    assign s_in = a_reg + rk;
    assign t = {sbox[s_in[31:24]], sbox[s_in[23:16]], sbox[s_in[15:8]], sbox[s_in[7:0]]};
    assign b_n = b_reg ^ {t[22:0], t[31:23]};
    assign c_n = c_reg - t;
    assign d_n = d_reg ^ {c_n[4:0], c_n[31:5]};
    assign done = done_reg;
    assign dout = {a_reg, b_reg, c_reg, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg <= 4'd0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 4'd1;
                if (rnd_reg == 4'(gcm_pkg::ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            {a_reg, b_reg, c_reg, d_reg} <= din;
        end
        else if (busy_reg)
        begin
            a_reg <= b_n;
            b_reg <= c_n;
            c_reg <= d_n;
            d_reg <= a_reg;
        end
    end

endmodule

### hdl/gcm_back.sv
module gcm_back #(
    parameter int unsigned FIELD_POLY = gcm_pkg::FIELD_POLY_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [255:0]    key,
    input  logic            job_valid,
    output logic            job_ready,
    input  gcm_pkg::job_t   job,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      kind,
    output logic [63:0]     oh,
    output logic [63:0]     ol
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HKEY,
        ST_MASK,
        ST_CTR,
        ST_GHASH,
        ST_TAG
    } state_t;

    state_t          state_reg;
    gcm_pkg::job_t   cur_reg;
    logic [127:0]    iv_reg;
    logic [127:0]    h_reg;
    logic [127:0]    mask_reg;
    logic [127:0]    acc_reg;
    logic [127:0]    x_reg;
    logic [127:0]    ct_reg;
    logic [31:0]     ctr_reg;
    logic [60:0]     aad_tot_reg;
    logic [60:0]     txt_tot_reg;
    logic            out_valid_reg;
    logic [1:0]      kind_reg;
    logic [127:0]    odata_reg;
    logic            c_start;
    logic [127:0]    c_din;
    logic            c_done;
    logic [127:0]    c_dout;
    logic [127:0]    prod;
    logic [127:0]    v;
    logic [127:0]    ct_masked;
    logic            take;
    logic            out_set;

    gcm_cipher #(.FIELD_POLY(FIELD_POLY)) u_cipher (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .din   (c_din),
        .key   (key),
        .done  (c_done),
        .dout  (c_dout)
    );

    // bit-reflected GF(2^128) product of x_reg and h_reg
    always_comb
    begin
        prod = '0;
        v = h_reg;
        for (int i = 0; i < 128; i++)
        begin
            if (x_reg[127 - i]) prod = prod ^ v;
            v = {1'b0, v[127:1]} ^ (v[0] ? {8'hE1, 120'd0} : 128'd0);
        end
    end

    assign job_ready = (state_reg == ST_IDLE) && !(out_valid_reg && !out_ready);
    assign take = job_valid && job_ready;
    assign ct_masked = (c_dout ^ {cur_reg.bh, cur_reg.bl}) & gcm_pkg::keep_mask(cur_reg.n);
    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign oh = odata_reg[127:64];
    assign ol = odata_reg[63:0];
    assign out_set = (take && job.err)
                   || (state_reg == ST_GHASH && cur_reg.cmd == gcm_pkg::CMD_TEXT)
                   || (state_reg == ST_TAG);

    always_comb
    begin
        c_start = 1'b0;
        c_din = '0;
        if (take && !job.err && job.cmd == gcm_pkg::CMD_START)
        begin
            c_start = 1'b1;
        end
        else if (take && !job.err && job.cmd == gcm_pkg::CMD_TEXT)
        begin
            c_start = 1'b1;
            c_din = iv_reg | {96'd0, ctr_reg + 32'd1};
        end
        else if (state_reg == ST_HKEY && c_done)
        begin
            c_start = 1'b1;
            c_din = iv_reg | 128'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            kind_reg <= gcm_pkg::KIND_CIPHER;
            cur_reg <= '0;
            iv_reg <= '0;
            h_reg <= '0;
            mask_reg <= '0;
            acc_reg <= '0;
            x_reg <= '0;
            ct_reg <= '0;
            odata_reg <= '0;
            ctr_reg <= 32'd1;
            aad_tot_reg <= '0;
            txt_tot_reg <= '0;
        end
        else
        begin
            if (out_set) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        cur_reg <= job;
                        if (job.err)
                        begin
                            kind_reg <= gcm_pkg::KIND_ERROR;
                            odata_reg <= '0;
                        end
                        else
                        begin
                            unique case (job.cmd)
                                gcm_pkg::CMD_START:
                                begin
                                    iv_reg <= {job.bh, job.bl[63:32], 32'd0};
                                    acc_reg <= '0;
                                    ctr_reg <= 32'd1;
                                    aad_tot_reg <= '0;
                                    txt_tot_reg <= '0;
                                    state_reg <= ST_HKEY;
                                end
                                gcm_pkg::CMD_AAD:
                                begin
                                    x_reg <= acc_reg ^ ({job.bh, job.bl}
                                             & gcm_pkg::keep_mask(job.n));
                                    aad_tot_reg <= aad_tot_reg + 61'(job.n);
                                    state_reg <= ST_GHASH;
                                end
                                gcm_pkg::CMD_TEXT:
                                begin
                                    ctr_reg <= ctr_reg + 32'd1;
                                    txt_tot_reg <= txt_tot_reg + 61'(job.n);
                                    state_reg <= ST_CTR;
                                end
                                gcm_pkg::CMD_FIN:
                                begin
                                    x_reg <= acc_reg ^ {aad_tot_reg, 3'd0, txt_tot_reg, 3'd0};
                                    state_reg <= ST_TAG;
                                end
                                default:
                                begin
                                    state_reg <= ST_IDLE;
                                end
                            endcase
                        end
                    end
                end
                ST_HKEY:
                begin
                    if (c_done)
                    begin
                        h_reg <= c_dout;
                        state_reg <= ST_MASK;
                    end
                end
                ST_MASK:
                begin
                    if (c_done)
                    begin
                        mask_reg <= c_dout;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_CTR:
                begin
                    if (c_done)
                    begin
                        x_reg <= acc_reg ^ ct_masked;
                        ct_reg <= ct_masked;
                        state_reg <= ST_GHASH;
                    end
                end
                ST_GHASH:
                begin
                    acc_reg <= prod;
                    if (cur_reg.cmd == gcm_pkg::CMD_TEXT)
                    begin
                        kind_reg <= gcm_pkg::KIND_CIPHER;
                        odata_reg <= ct_reg;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_TAG:
                begin
                    acc_reg <= prod;
                    kind_reg <= gcm_pkg::KIND_TAG;
                    odata_reg <= prod ^ mask_reg;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/gcm_authenticated_encryption.sv
// GCM encryption with a simplified eight-round 128-bit cipher under a 256-bit key
// written through the four key registers. Send a start transaction carrying the IV,
// then AAD blocks, then plaintext blocks, then finish; each plaintext block returns
// one ciphertext transaction, finish returns the tag, and a transaction out of
// order returns an error kind with zero data. Start runs two cipher passes of eight
// rounds each (the hash key, then the mask) and returns to idle; a plaintext block
// runs one pass (eight rounds, one per cycle), the GHASH multiply and the return to
// idle; an AAD block or finish runs the GHASH multiply and returns to idle. The
// single round unit serves every pass. A two-entry queue sits between the classifier
// and the execution unit.
module gcm_authenticated_encryption #(
    parameter int unsigned FIELD_POLY = gcm_pkg::FIELD_POLY_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // block_high, block_low, byte_count
    input  logic [1:0]    s_axis_tuser,   // operation
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // out_high, out_low
    output logic [1:0]    m_axis_tuser,   // result_kind
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    logic [63:0]      key_reg [4];
    logic             job_valid;
    logic             job_ready;
    gcm_pkg::job_t    job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    gcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .op        (s_axis_tuser),
        .bh        (s_axis_tdata[63:0]),
        .bl        (s_axis_tdata[127:64]),
        .n         (s_axis_tdata[132:128]),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    gcm_back #(.FIELD_POLY(FIELD_POLY)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .kind      (m_axis_tuser),
        .oh        (m_axis_tdata[63:0]),
        .ol        (m_axis_tdata[127:64])
    );

`ifndef ASSERT_OFF
    a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= gcm_pkg::KIND_ERROR)) else $error("bad result kind");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == gcm_pkg::KIND_ERROR) |-> (m_axis_tdata == '0))
        else $error("error result carries data");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif

endmodule

### tb/gcm_authenticated_encryption_test.sv
`timescale 1ns / 100ps

module gcm_authenticated_encryption_test;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_AAD  = 2'd1,
        PH_TEXT = 2'd2
    } phase_t;

    typedef struct {
        gcm_pkg::kind_t  kind;
        logic [63:0]     hi;
        logic [63:0]     lo;
    } result_t;

    typedef struct {
        gcm_pkg::op_t  op;
        logic [63:0]   bh;
        logic [63:0]   bl;
        logic [4:0]    n;
        bit            fixed;
        result_t       res;
    } row_t;

    localparam int IDLE_WAIT = 80;
    localparam int LONG_HOLD = 400;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [135:0]  s_axis_tdata;   // block_high, block_low, byte_count
    logic [1:0]    s_axis_tuser;   // operation
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [127:0]  m_axis_tdata;   // out_high, out_low
    logic [1:0]    m_axis_tuser;   // result_kind
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [63:0]   cfg_data;

    gcm_authenticated_encryption dut (.*);

    logic [7:0]    sub_table [256];
    logic [63:0]   key_reg [4];
    logic [127:0]  iv_word;
    logic [127:0]  hash_key;
    logic [127:0]  mask_word;
    logic [127:0]  auth_acc;
    logic [31:0]   ctr;
    logic [60:0]   aad_bytes;
    logic [60:0]   text_bytes;
    phase_t        phase;

    result_t       pending_results [$];
    int            mismatches;
    int            items_sent;
    int            results_seen;
    int            burst_left;
    int            hold_left;
    bit            hold_go;

    function automatic logic [7:0] field_mul(logic [7:0] x, logic [7:0] y);
        logic [7:0] acc;
        acc = 8'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (y[k]) acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h69 : 8'h00);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sub_bytes(logic [31:0] w);
        return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
    endfunction

    function automatic logic [127:0] encrypt(logic [127:0] blk);
        logic [31:0] a, b, c, d, t, rk, old;
        {a, b, c, d} = blk;
        for (int i = 0; i < 8; i++)
        begin
            rk = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
            t = sub_bytes(a + rk);
            b ^= {t[22:0], t[31:23]};
            c -= t;
            d ^= {c[4:0], c[31:5]};
            old = a; a = b; b = c; c = d; d = old;
        end
        return {a, b, c, d};
    endfunction

    function automatic logic [127:0] auth_mul(logic [127:0] x, logic [127:0] h);
        logic [127:0] z, v;
        logic lsb;
        z = '0;
        v = h;
        for (int i = 0; i < 128; i++)
        begin
            lsb = v[0];
            if (x[127 - i]) z ^= v;
            v = v >> 1;
            if (lsb) v[127:120] ^= 8'hE1;
        end
        return z;
    endfunction

    function automatic logic [127:0] byte_keep(logic [4:0] n);
        logic [127:0] m;
        for (int i = 0; i < 16; i++)
            m[127 - 8 * i -: 8] = (i < n) ? 8'hFF : 8'h00;
        return m;
    endfunction

    task automatic predict_gcm(input gcm_pkg::op_t op, input logic [63:0] bh,
                               input logic [63:0] bl, input logic [4:0] n,
                               output bit has, output result_t r);
        logic [127:0] ks;
        bit size_ok;
        size_ok = (n >= 1) && (n <= 16);
        has = 1;
        r.kind = gcm_pkg::KIND_ERROR;
        r.hi = '0;
        r.lo = '0;
        if (op == gcm_pkg::OP_START)
        begin
            iv_word = {bh, bl[63:32], 32'd0};
            hash_key = encrypt('0);
            mask_word = encrypt(iv_word | 128'd1);
            auth_acc = '0;
            ctr = 32'd1;
            aad_bytes = '0;
            text_bytes = '0;
            phase = PH_AAD;
            has = 0;
        end
        else if (op == gcm_pkg::OP_AAD && phase == PH_AAD && size_ok)
        begin
            auth_acc = auth_mul(auth_acc ^ ({bh, bl} & byte_keep(n)), hash_key);
            aad_bytes += n;
            has = 0;
        end
        else if (op == gcm_pkg::OP_TEXT && phase != PH_IDLE && size_ok)
        begin
            ctr += 1;
            ks = (encrypt(iv_word | ctr) ^ {bh, bl}) & byte_keep(n);
            auth_acc = auth_mul(auth_acc ^ ks, hash_key);
            text_bytes += n;
            phase = PH_TEXT;
            r.kind = gcm_pkg::KIND_CIPHER;
            {r.hi, r.lo} = ks;
        end
        else if (op == gcm_pkg::OP_FIN && phase != PH_IDLE)
        begin
            auth_acc = auth_mul(auth_acc ^ {aad_bytes, 3'd0, text_bytes, 3'd0}, hash_key);
            r.kind = gcm_pkg::KIND_TAG;
            {r.hi, r.lo} = auth_acc ^ mask_word;
            phase = PH_IDLE;
        end
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind %0d data %h", m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                result_t e;
                e = pending_results.pop_front();
                if (m_axis_tuser !== e.kind || m_axis_tdata !== {e.lo, e.hi})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d %h_%h, got kind %0d %h_%h",
                                 e.kind, e.hi, e.lo, m_axis_tuser,
                                 m_axis_tdata[63:0], m_axis_tdata[127:64]);
                end
            end
        end
        if (hold_go)
        begin
            hold_left = LONG_HOLD;
            hold_go = 0;
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case ((results_seen / 50) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(1, 0);
                default: m_axis_tready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    task automatic send_item(input gcm_pkg::op_t op, input logic [63:0] bh,
                             input logic [63:0] bl, input logic [4:0] n,
                             input bit fixed, input result_t fixed_res);
        bit has;
        result_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'd0, n, bl, bh};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
        predict_gcm(op, bh, bl, n, has, r);
        if (fixed)
        begin
            has = 1;
            r = fixed_res;
        end
        if (has) pending_results.push_back(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(12, 0);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_keys(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3);
        logic [63:0] k [4];
        k = '{k0, k1, k2, k3};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data <= k[i];
            key_reg[i] = k[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [4:0] rand_count();
        case ($urandom_range(9, 0))
            0, 1, 2: return 5'd16;
            3: return 5'd1;
            default: return 5'($urandom_range(16, 1));
        endcase
    endfunction

    task automatic random_traffic(input int budget);
        result_t none;
        int goal;
        none = '{gcm_pkg::KIND_ERROR, 64'd0, 64'd0};
        goal = items_sent + budget;
        while (items_sent < goal)
        begin
            if ($urandom_range(9, 0) == 0)
                send_item(gcm_pkg::op_t'($urandom_range(3, 0)), rand64(), rand64(),
                          5'($urandom_range(31, 0)), 0, none);
            else
            begin
                send_item(gcm_pkg::OP_START, rand64(), rand64(), rand_count(), 0, none);
                repeat ($urandom_range(3, 0))
                    send_item(gcm_pkg::OP_AAD, rand64(), rand64(), rand_count(), 0, none);
                repeat ($urandom_range(6, 0))
                    send_item(gcm_pkg::OP_TEXT, rand64(), rand64(), rand_count(), 0, none);
                if ($urandom_range(7, 0) != 0)
                    send_item(gcm_pkg::OP_FIN, rand64(), rand64(),
                              5'($urandom_range(31, 0)), 0, none);
            end
        end
    endtask

    initial
    begin
        row_t rows [$];
        result_t err;
        result_t none;
        logic [7:0] p;
        int waited;
        err = '{gcm_pkg::KIND_ERROR, 64'd0, 64'd0};
        none = err;
        for (int v = 0; v < 256; v++)
        begin
            p = 8'(v);
            if (v == 0)
                p = 8'd0;
            else
                repeat (253) p = field_mul(p, 8'(v));
            for (int b = 0; b < 8; b++)
                sub_table[v][b] = p[b] ^ p[(b + 4) % 8] ^ p[(b + 5) % 8] ^ p[(b + 6) % 8]
                                ^ p[(b + 7) % 8] ^ ((8'h63 >> b) & 1);
        end
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        iv_word = '0; hash_key = '0; mask_word = '0; auth_acc = '0;
        ctr = 32'd1; aad_bytes = '0; text_bytes = '0; phase = PH_IDLE;
        mismatches = 0; items_sent = 0; results_seen = 0;
        burst_left = 0; hold_left = 0; hold_go = 0;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{gcm_pkg::OP_AAD,   '1,  '1,  5'd16, 1, err},
            '{gcm_pkg::OP_TEXT,  '0,  '0,  5'd1,  1, err},
            '{gcm_pkg::OP_FIN,   '0,  '0,  5'd0,  1, err},
            '{gcm_pkg::OP_START, '0,  '0,  5'd0,  0, none},
            '{gcm_pkg::OP_AAD,   '1,  '1,  5'd0,  1, err},
            '{gcm_pkg::OP_AAD,   '1,  '1,  5'd17, 1, err},
            '{gcm_pkg::OP_TEXT,  '1,  '1,  5'd31, 1, err},
            '{gcm_pkg::OP_AAD,   '1,  '1,  5'd16, 0, none},
            '{gcm_pkg::OP_AAD,   64'h0123456789ABCDEF, '1, 5'd1, 0, none},
            '{gcm_pkg::OP_AAD,   '1,  '1,  5'd9,  0, none},
            '{gcm_pkg::OP_TEXT,  '0,  '0,  5'd16, 0, none},
            '{gcm_pkg::OP_TEXT,  '1,  '1,  5'd1,  0, none},
            '{gcm_pkg::OP_TEXT,  '1,  '1,  5'd8,  0, none},
            '{gcm_pkg::OP_AAD,   '1,  '1,  5'd4,  1, err},
            '{gcm_pkg::OP_TEXT,  '1,  '1,  5'd15, 0, none},
            '{gcm_pkg::OP_FIN,   '1,  '1,  5'd31, 0, none},
            '{gcm_pkg::OP_FIN,   '0,  '0,  5'd16, 1, err},
            '{gcm_pkg::OP_START, '1,  '1,  5'd31, 0, none},
            '{gcm_pkg::OP_FIN,   '0,  '0,  5'd1,  0, none},
            '{gcm_pkg::OP_START, 64'hFEDCBA9876543210, 64'h89ABCDEF_FFFFFFFF, 5'd16, 0, none},
            '{gcm_pkg::OP_TEXT,  '1,  '0,  5'd16, 0, none},
            '{gcm_pkg::OP_START, '0,  '0,  5'd8,  0, none},
            '{gcm_pkg::OP_TEXT,  '0,  '1,  5'd16, 0, none},
            '{gcm_pkg::OP_FIN,   '0,  '0,  5'd16, 0, none}
        };
        foreach (rows[i])
            send_item(rows[i].op, rows[i].bh, rows[i].bl, rows[i].n, rows[i].fixed, rows[i].res);

        write_keys('1, '1, '1, '1);
        random_traffic(400);

        write_keys(rand64(), rand64(), rand64(), rand64());
        hold_go = 1;
        random_traffic(200);
        drain();
        random_traffic(200);

        write_keys(64'h8000000000000001, '0, 64'h0123456789ABCDEF, '1);
        random_traffic(400);

        write_keys(rand64(), rand64(), rand64(), rand64());
        random_traffic(350);

        write_keys(rand64(), rand64(), rand64(), rand64());
        random_traffic(350);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (IDLE_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d results never arrived", pending_results.size());
        end
        $display("sent %0d items under six key settings, checked %0d results, %0d mismatches",
                 items_sent, results_seen, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
